// ----- rtl/mvp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared constants, controller states and command/status types for the
// minimum-variance partition block.
// ----------------------------------------------------------------------------
package mvp_pkg;

  localparam int MAX_ITEMS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 12;
  localparam int SEG_W          = 11;
  localparam int OUT_W          = 55;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  typedef enum logic [5:0] {
    S_IDLE,
    S_CHECK,
    S_INIT_RD,
    S_INIT_WR,
    S_ROW,
    S_J_RD,
    S_J_LAT,
    S_POP,
    S_POP_QA,
    S_POP_QB_RD,
    S_POP_QB,
    S_POP_PA_RD,
    S_POP_PA,
    S_POP_PB_RD,
    S_POP_PB,
    S_POP_MUL,
    S_POP_WAIT,
    S_POP_TEST,
    S_BEST_RD,
    S_BEST_Q,
    S_BEST_PRD,
    S_BEST_PL,
    S_BEST_WR,
    S_PUSH,
    S_PUSH_QA,
    S_PUSH_QB_RD,
    S_PUSH_QB,
    S_PUSH_PA_RD,
    S_PUSH_PA,
    S_PUSH_PB_RD,
    S_PUSH_PB,
    S_PUSH_MUL,
    S_PUSH_WAIT,
    S_PUSH_TEST,
    S_ROW_END,
    S_FIN_RD,
    S_FIN_MUL,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_ZERO,
    OP_INIT_BEGIN,
    OP_PT_RD,
    OP_INIT_WR,
    OP_ROW_BEGIN,
    OP_PT_LATCH,
    OP_Q_RD,
    OP_Q_LATCH,
    OP_SET_L1,
    OP_MUL_START,
    OP_MUL_STORE,
    OP_HEAD_INC,
    OP_TAIL_DEC,
    OP_WRITE_COST,
    OP_PUSH,
    OP_ROW_END,
    OP_FIN_PRODUCT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {IDX_J, IDX_A, IDX_B, IDX_N} idx_sel_t;
  typedef enum logic [1:0] {Q_HEAD, Q_HEAD1, Q_TAILM1, Q_TAIL} q_sel_t;
  typedef enum logic [1:0] {PT_A, PT_B, PT_J} pt_sel_t;
  typedef enum logic [1:0] {MUL_POP_R, MUL_PUSH_L, MUL_PUSH_R} mul_sel_t;
  typedef enum logic {RES_L, RES_R} res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    idx_sel_t idx;
    q_sel_t   qsel;
    pt_sel_t  pt;
    mul_sel_t mul;
    res_sel_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic head_lt_tail;
    logic j_eq_n;
    logic i_last;
    logic trivial;
    logic less;
    logic mul_busy;
  } dp_status_t;

endpackage

// ----- rtl/mvp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvp_ctrl
// Sequencer for loading, the cost rows, the hull queue tests and the final
// result; drives the datapath through one command per cycle.
// ----------------------------------------------------------------------------
module mvp_ctrl
  import mvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       last_item,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;
  logic   mul_second;
  logic   mul_second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mul_second <= 1'b0;
    end else begin
      state      <= state_next;
      mul_second <= mul_second_next;
    end
  end

  always_comb begin
    state_next      = state;
    mul_second_next = mul_second;
    cmd             = '{op: OP_NONE, idx: IDX_J, qsel: Q_HEAD, pt: PT_A,
                        mul: MUL_POP_R, res: RES_L};
    busy            = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (last_item) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.trivial) begin
          cmd.op     = OP_EMIT_ZERO;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_INIT_BEGIN;
          state_next = S_INIT_RD;
        end
      end
      S_INIT_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_J;
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.op     = OP_INIT_WR;
        state_next = status.j_eq_n ? S_ROW : S_INIT_RD;
      end
      S_ROW: begin
        cmd.op     = OP_ROW_BEGIN;
        state_next = S_J_RD;
      end
      S_J_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_J;
        state_next = S_J_LAT;
      end
      S_J_LAT: begin
        cmd.op     = OP_PT_LATCH;
        cmd.pt     = PT_J;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.op     = OP_Q_RD;
        cmd.qsel   = Q_HEAD;
        state_next = status.head_lt_tail ? S_POP_QA : S_BEST_Q;
      end
      S_POP_QA: begin
        cmd.op     = OP_Q_LATCH;
        cmd.pt     = PT_A;
        state_next = S_POP_QB_RD;
      end
      S_POP_QB_RD: begin
        cmd.op     = OP_Q_RD;
        cmd.qsel   = Q_HEAD1;
        state_next = S_POP_QB;
      end
      S_POP_QB: begin
        cmd.op     = OP_Q_LATCH;
        cmd.pt     = PT_B;
        state_next = S_POP_PA_RD;
      end
      S_POP_PA_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_A;
        state_next = S_POP_PA;
      end
      S_POP_PA: begin
        cmd.op     = OP_PT_LATCH;
        cmd.pt     = PT_A;
        state_next = S_POP_PB_RD;
      end
      S_POP_PB_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_B;
        state_next = S_POP_PB;
      end
      S_POP_PB: begin
        cmd.op     = OP_PT_LATCH;
        cmd.pt     = PT_B;
        state_next = S_POP_MUL;
      end
      S_POP_MUL: begin
        cmd.op     = OP_MUL_START;
        cmd.mul    = MUL_POP_R;
        state_next = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        if (!status.mul_busy) begin
          cmd.op     = OP_MUL_STORE;
          cmd.res    = RES_R;
          state_next = S_POP_TEST;
        end else begin
          cmd.op     = OP_SET_L1;
        end
      end
      S_POP_TEST: begin
        if (status.less) begin
          cmd.op     = OP_HEAD_INC;
          state_next = S_POP;
        end else begin
          state_next = S_BEST_RD;
        end
      end
      S_BEST_RD: begin
        cmd.op     = OP_Q_RD;
        cmd.qsel   = Q_HEAD;
        state_next = S_BEST_Q;
      end
      S_BEST_Q: begin
        cmd.op     = OP_Q_LATCH;
        cmd.pt     = PT_A;
        state_next = S_BEST_PRD;
      end
      S_BEST_PRD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_A;
        state_next = S_BEST_PL;
      end
      S_BEST_PL: begin
        cmd.op     = OP_PT_LATCH;
        cmd.pt     = PT_A;
        state_next = S_BEST_WR;
      end
      S_BEST_WR: begin
        cmd.op     = OP_WRITE_COST;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.head_lt_tail) begin
          cmd.op     = OP_Q_RD;
          cmd.qsel   = Q_TAILM1;
          state_next = S_PUSH_QA;
        end else begin
          cmd.op     = OP_PUSH;
          state_next = status.j_eq_n ? S_ROW_END : S_J_RD;
        end
      end
      S_PUSH_QA: begin
        cmd.op     = OP_Q_LATCH;
        cmd.pt     = PT_A;
        state_next = S_PUSH_QB_RD;
      end
      S_PUSH_QB_RD: begin
        cmd.op     = OP_Q_RD;
        cmd.qsel   = Q_TAIL;
        state_next = S_PUSH_QB;
      end
      S_PUSH_QB: begin
        cmd.op     = OP_Q_LATCH;
        cmd.pt     = PT_B;
        state_next = S_PUSH_PA_RD;
      end
      S_PUSH_PA_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_A;
        state_next = S_PUSH_PA;
      end
      S_PUSH_PA: begin
        cmd.op     = OP_PT_LATCH;
        cmd.pt     = PT_A;
        state_next = S_PUSH_PB_RD;
      end
      S_PUSH_PB_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_B;
        state_next = S_PUSH_PB;
      end
      S_PUSH_PB: begin
        cmd.op          = OP_PT_LATCH;
        cmd.pt          = PT_B;
        mul_second_next = 1'b0;
        state_next      = S_PUSH_MUL;
      end
      // left product first, then right product
      S_PUSH_MUL: begin
        cmd.op     = OP_MUL_START;
        cmd.mul    = mul_second ? MUL_PUSH_R : MUL_PUSH_L;
        state_next = S_PUSH_WAIT;
      end
      S_PUSH_WAIT: begin
        if (!status.mul_busy) begin
          cmd.op  = OP_MUL_STORE;
          cmd.res = mul_second ? RES_R : RES_L;
          if (mul_second) begin
            state_next = S_PUSH_TEST;
          end else begin
            mul_second_next = 1'b1;
            state_next      = S_PUSH_MUL;
          end
        end
      end
      S_PUSH_TEST: begin
        if (status.less) begin
          cmd.op     = OP_TAIL_DEC;
          state_next = S_PUSH;
        end else begin
          cmd.op     = OP_PUSH;
          state_next = status.j_eq_n ? S_ROW_END : S_J_RD;
        end
      end
      S_ROW_END: begin
        cmd.op     = OP_ROW_END;
        state_next = status.i_last ? S_FIN_RD : S_ROW;
      end
      S_FIN_RD: begin
        cmd.op     = OP_PT_RD;
        cmd.idx    = IDX_N;
        state_next = S_FIN_MUL;
      end
      S_FIN_MUL: begin
        cmd.op     = OP_FIN_PRODUCT;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.op     = OP_EMIT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mvp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvp_datapath
// Prefix-sum, cost and hull queue memories, point registers, bit-serial
// signed multiplier for the slope tests and the result arithmetic.
// ----------------------------------------------------------------------------
module mvp_datapath
  import mvp_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last_item,
  input  logic [SEG_W-1:0]      segment_count,
  output dp_status_t            status,
  output logic                  done,
  output logic [OUT_W-1:0]      weighted_variance,
  output logic                  segments_invalid
);

  localparam int IW   = $clog2(MAX_ITEMS + 1);
  localparam int PS_W = VALUE_BITS + $clog2(MAX_ITEMS);
  localparam int CW   = 2 * PS_W;
  localparam int YW   = CW + 1;
  localparam int AW   = YW + 1;
  localparam int BW   = PS_W + 1;
  localparam int PW   = AW + BW;
  localparam int MCW  = $clog2(BW);
  localparam int FW   = CW + SEG_W;
  localparam int XW   = (FW > OUT_W) ? FW : OUT_W;
  localparam int MW   = ((IW + 1) > SEG_W) ? (IW + 1) : SEG_W;

  logic [PS_W-1:0] ps_mem [0:MAX_ITEMS];
  logic [CW-1:0]   cost_mem [0:1][0:MAX_ITEMS];
  logic [IW-1:0]   q_mem [0:MAX_ITEMS];

  logic [IW-1:0]   cnt, n, i, j, head, tail, ia, ib;
  logic [PS_W-1:0] total, xa, xb, xj, ps_q;
  logic [YW-1:0]   ya, yb, yj;
  logic [CW-1:0]   ca, cost_q, total2;
  logic [IW-1:0]   q_q;
  logic signed [PW-1:0] lhs, rhs, acc, mc;
  logic [BW-1:0]   mp;
  logic [MCW-1:0]  mcnt;
  logic            mul_run;
  logic [FW-1:0]   fin_prod;

  logic [IW-1:0]   cnt_up, rd_idx, q_addr;
  logic            room;
  logic [PS_W-1:0] total_new, d_best;
  logic [YW-1:0]   y_new;
  logic signed [BW-1:0] dx_ba, dx_ja;
  logic signed [AW-1:0] dy_ba, dy_ja, mul_a;
  logic signed [BW-1:0] mul_b;
  logic [MW-1:0]   m_ext, n_ext, i1_ext;
  logic            seg_bad;
  logic [XW-1:0]   diff_ext;
  logic [OUT_W-1:0] res;

  assign room      = (cnt < IW'(MAX_ITEMS));
  assign cnt_up    = cnt + 1'b1;
  assign total_new = ((cnt == '0) ? '0 : total) + PS_W'(value);
  assign y_new     = YW'(cost_q) + YW'(ps_q * ps_q);
  assign d_best    = xj - xa;

  assign dx_ba = $signed({1'b0, xb}) - $signed({1'b0, xa});
  assign dx_ja = $signed({1'b0, xj}) - $signed({1'b0, xa});
  assign dy_ba = $signed({1'b0, yb}) - $signed({1'b0, ya});
  assign dy_ja = $signed({1'b0, yj}) - $signed({1'b0, ya});

  always_comb begin
    case (cmd.idx)
      IDX_J:   rd_idx = j;
      IDX_A:   rd_idx = ia;
      IDX_B:   rd_idx = ib;
      IDX_N:   rd_idx = n;
      default: rd_idx = j;
    endcase
    case (cmd.qsel)
      Q_HEAD:   q_addr = head;
      Q_HEAD1:  q_addr = head + 1'b1;
      Q_TAILM1: q_addr = tail - 1'b1;
      Q_TAIL:   q_addr = tail;
      default:  q_addr = head;
    endcase
    case (cmd.mul)
      MUL_POP_R: begin
        mul_a = $signed({{(AW-PS_W-1){1'b0}}, xj, 1'b0});
        mul_b = dx_ba;
      end
      MUL_PUSH_L: begin
        mul_a = dy_ja;
        mul_b = dx_ba;
      end
      MUL_PUSH_R: begin
        mul_a = dy_ba;
        mul_b = dx_ja;
      end
      default: begin
        mul_a = dy_ba;
        mul_b = dx_ja;
      end
    endcase
  end

  assign m_ext   = MW'(segment_count);
  assign n_ext   = MW'(n);
  assign i1_ext  = MW'(i) + 1'b1;
  assign seg_bad = (m_ext == '0) || (m_ext > n_ext);

  assign status.head_lt_tail = (head < tail);
  assign status.j_eq_n       = (j == n);
  assign status.i_last       = (i1_ext == m_ext);
  assign status.trivial      = seg_bad || (m_ext == MW'(1));
  assign status.less         = (lhs < rhs);
  assign status.mul_busy     = mul_run;

  always_comb begin
    diff_ext = XW'(fin_prod) - XW'(total2);
    if (fin_prod < FW'(total2)) begin
      res = '0;
    end else if (diff_ext > XW'({OUT_W{1'b1}})) begin
      res = {OUT_W{1'b1}};
    end else begin
      res = OUT_W'(diff_ext);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && room) begin
      ps_mem[cnt_up] <= total_new;
    end
    if (cmd.op == OP_PT_RD) begin
      ps_q   <= ps_mem[rd_idx];
      cost_q <= cost_mem[~i[0]][rd_idx];
    end
    if (cmd.op == OP_INIT_WR) begin
      cost_mem[1'b0][j] <= CW'(ps_q * ps_q);
    end else if (cmd.op == OP_WRITE_COST) begin
      cost_mem[i[0]][j] <= ca + CW'(d_best * d_best);
    end
    if (cmd.op == OP_ROW_BEGIN) begin
      q_mem[IW'(1)] <= i;
    end else if (cmd.op == OP_PUSH) begin
      q_mem[tail + 1'b1] <= j;
    end
    if (cmd.op == OP_Q_RD) begin
      q_q <= q_mem[q_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      done    <= 1'b0;
      mul_run <= 1'b0;
    end else begin
      done <= (cmd.op == OP_EMIT_ZERO) || (cmd.op == OP_EMIT);
      if (cmd.op == OP_LOAD) begin
        if (last_item) begin
          cnt <= '0;
        end else if (room) begin
          cnt <= cnt_up;
        end
      end
      if (cmd.op == OP_MUL_START) begin
        mul_run <= 1'b1;
      end else if (mul_run && mcnt == MCW'(BW - 1)) begin
        mul_run <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (room) total <= total_new;
        if (last_item) n <= room ? cnt_up : cnt;
      end
      OP_EMIT_ZERO: begin
        weighted_variance <= '0;
        segments_invalid  <= seg_bad;
      end
      OP_INIT_BEGIN: begin
        j <= IW'(1);
        i <= IW'(1);
      end
      OP_INIT_WR: j <= j + 1'b1;
      OP_ROW_BEGIN: begin
        head <= IW'(1);
        tail <= IW'(1);
        j    <= i + 1'b1;
      end
      OP_PT_LATCH: begin
        case (cmd.pt)
          PT_A: begin
            xa <= ps_q;
            ya <= y_new;
            ca <= cost_q;
          end
          PT_B: begin
            xb <= ps_q;
            yb <= y_new;
          end
          default: begin
            xj <= ps_q;
            yj <= y_new;
          end
        endcase
      end
      OP_Q_LATCH: begin
        if (cmd.pt == PT_B) ib <= q_q;
        else ia <= q_q;
      end
      OP_SET_L1: lhs <= {{(PW-AW){dy_ba[AW-1]}}, dy_ba};
      OP_MUL_STORE: begin
        if (cmd.res == RES_R) rhs <= acc;
        else lhs <= acc;
      end
      OP_HEAD_INC: head <= head + 1'b1;
      OP_TAIL_DEC: tail <= tail - 1'b1;
      OP_PUSH: begin
        tail <= tail + 1'b1;
        j    <= j + 1'b1;
      end
      OP_ROW_END: i <= i + 1'b1;
      OP_FIN_PRODUCT: begin
        fin_prod <= FW'(cost_q * segment_count);
        total2   <= CW'(total * total);
      end
      OP_EMIT: begin
        weighted_variance <= res;
        segments_invalid  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // bit-serial signed multiplier, sign bit of the multiplier weighs negative
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL_START) begin
      acc  <= '0;
      mc   <= {{BW{mul_a[AW-1]}}, mul_a};
      mp   <= mul_b;
      mcnt <= '0;
    end else if (mul_run) begin
      if (mp[0]) begin
        acc <= (mcnt == MCW'(BW - 1)) ? (acc - mc) : (acc + mc);
      end
      mc   <= mc <<< 1;
      mp   <= mp >> 1;
      mcnt <= mcnt + 1'b1;
    end
  end

endmodule

// ----- rtl/min_variance_partition_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_variance_partition_dp
// Splits a loaded sequence into segment_count contiguous segments with the
// least sum of squared segment sums and reports segments times that minimum
// less the total squared.
// ----------------------------------------------------------------------------
// Values are taken one per cycle while busy is low. The transaction carrying
// last_item raises busy while the rows are computed: the first row is
// seeded, then for each of the m-1 further rows and each column a pass of
// the hull queue runs whose length is set by the bit-serial multiplier (one
// product per head test, two per tail test). A trivial segment count skips
// the rows. The result appears for one cycle with done and must be taken
// then, as the receiver cannot stall.
module min_variance_partition_dp
  import mvp_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last_item,
  output logic                  done,
  output logic [OUT_W-1:0]      weighted_variance,
  output logic                  segments_invalid,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  logic [SEG_W-1:0] segment_count;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == 1'b0) ? APB_DW'(segment_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_W'(1);
    end else if (psel && penable && pwrite && paddr[APB_AW-1] == 1'b0) begin
      segment_count <= pwdata[SEG_W-1:0];
    end
  end

  mvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  mvp_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .value             (value),
    .last_item         (last_item),
    .segment_count     (segment_count),
    .status            (status),
    .done              (done),
    .weighted_variance (weighted_variance),
    .segments_invalid  (segments_invalid)
  );

endmodule
